>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Expression must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: invariant");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst_n, expr)

`endif

`endif

>>> rtl/smil_pkg.sv
// ----------------------------------------------------------------------------
// smil_pkg
// Types, constants and codes for the sorted merge index lookup.
// ----------------------------------------------------------------------------
package smil_pkg;

  localparam int DICT_DEPTH = 1024;
  localparam int KEY_WIDTH  = 64;
  localparam int ADDR_W     = $clog2(DICT_DEPTH);
  localparam int CNT_W      = $clog2(DICT_DEPTH + 1);
  localparam int OUT_W      = 10;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic        last_in_run;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] match_index;
    logic [OUT_W-1:0] result_slot;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_en;
    logic clear_en;
    logic query_start;
    logic advance;
    logic emit;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;
    logic key_lt;
    logic key_eq;
    logic out_free;
  } status_t;

endpackage

>>> rtl/smil_ctrl.sv
// ----------------------------------------------------------------------------
// smil_ctrl
// Controller: takes transfers in IDLE, steps the merge scan in CMP.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smil_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_ready,
  input  smil_pkg::status_t status,
  output smil_pkg::cmd_t    cmd
);
  import smil_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            FUNC_LOAD:  cmd.load_en  = 1'b1;
            FUNC_CLEAR: cmd.clear_en = 1'b1;
            FUNC_QUERY: begin
              cmd.query_start = 1'b1;
              state_nxt       = ST_CMP;
            end
            default: ;  // unused code: dropped
          endcase
        end
      end
      ST_CMP: begin
        if (!status.in_range) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (status.key_lt) begin
          cmd.advance = 1'b1;
        end else if (status.key_eq) begin
          // hold until the output register can take the result
          if (status.out_free) begin
            cmd.emit   = 1'b1;
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ASSERT_ALWAYS(a_cmd_onehot, clk, rst_n, $onehot0({cmd.advance, cmd.emit, cmd.query_start}))
  `ASSERT_NEXT(a_query_enters_cmp, clk, rst_n, cmd.query_start, state_r == ST_CMP)
  `ASSERT_IMPLIES(a_ready_only_idle, clk, rst_n, in_ready, state_r == ST_IDLE)

endmodule

>>> rtl/smil_dp.sv
// ----------------------------------------------------------------------------
// smil_dp
// Datapath: key memory, entry count, scan pointer, match counter, output reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smil_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  smil_pkg::in_t     in_data,
  input  smil_pkg::cmd_t    cmd,
  output smil_pkg::status_t status,
  output logic              out_valid,
  input  logic              out_ready,
  output smil_pkg::out_t    out_data
);
  import smil_pkg::*;

  logic [KEY_WIDTH-1:0] mem [DICT_DEPTH];
  logic [KEY_WIDTH-1:0] rdata_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic                 last_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     ptr_r, ptr_nxt;
  logic [OUT_W-1:0]     match_cnt_r, match_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 not_full;

  assign not_full = count_r < CNT_W'(DICT_DEPTH);

  // Next read follows the pointer so rdata_r always holds mem[ptr_r] in CMP.
  assign rd_addr = cmd.advance ? ADDR_W'(ptr_r + CNT_W'(1)) : ptr_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_en && not_full) begin
      mem[count_r[ADDR_W-1:0]] <= in_data.key[KEY_WIDTH-1:0];
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      key_r  <= in_data.key[KEY_WIDTH-1:0];
      last_r <= in_data.last_in_run;
    end
    if (cmd.emit) begin
      out_data_r.match_index <= OUT_W'(ptr_r);
      out_data_r.result_slot <= match_cnt_r;
    end
  end

  always_comb begin
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    match_cnt_nxt = match_cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_en && not_full) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.clear_en) begin
      count_nxt     = '0;
      ptr_nxt       = '0;
      match_cnt_nxt = '0;
    end
    if (cmd.advance) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end
    if (cmd.emit) begin
      ptr_nxt       = ptr_r + CNT_W'(1);
      match_cnt_nxt = match_cnt_r + OUT_W'(1);
      out_valid_nxt = 1'b1;
    end
    if (cmd.finish && last_r) begin
      ptr_nxt       = '0;
      match_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      match_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      match_cnt_r <= match_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.in_range = ptr_r < count_r;
  assign status.key_lt   = rdata_r < key_r;
  assign status.key_eq   = rdata_r == key_r;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPLIES(a_emit_on_match, clk, rst_n, cmd.emit, status.in_range && status.key_eq)
  `ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.clear_en, count_r == '0 && ptr_r == '0)
  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(DICT_DEPTH))
  `ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit, out_valid_r)

endmodule

>>> rtl/sorted_merge_index_lookup.sv
// Load and clear stay in IDLE, so a new transfer is taken the next cycle.
// Query: IDLE takes the key; CMP reads through the single registered read
// port of the key memory, one entry compared per cycle while no match waits.
// A match appears in the output register in the cycle after its compare; a full
// output register holds the query in compare until the result is taken.
// Reset (rst_n, synchronous, active low) empties the dictionary and zeroes
// pointer and match counter; the key memory itself is not cleared.
// ----------------------------------------------------------------------------
// sorted_merge_index_lookup
// Sorted-set intersection by merge: ascending queries against a loaded
// dictionary of ascending keys, returning index and slot of each match.
// ----------------------------------------------------------------------------
module sorted_merge_index_lookup (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  smil_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output smil_pkg::out_t out_data
);
  import smil_pkg::*;

  // Controller and datapath talk only through these two bundles.
  cmd_t    cmd;
  status_t status;

  // FSM: IDLE takes every transfer; a query moves to CMP, which walks the
  // pointer past smaller keys and ends on a match, a larger key or the end
  // of the dictionary. A match waits in CMP while the output is occupied.
  smil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Key memory, counters and the output register. The output register lets
  // the next transfer in while a result is still waiting to be taken.
  smil_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
